### rtl/kab_pkg.sv
// Shared types, codes and sign-extension and saturation helpers of the angle/bias Kalman filter.
`timescale 1ns / 1ps

package kab_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MA, ST_WA, ST_WB, ST_MC, ST_WC, ST_WD, ST_DIV0, ST_D1GO, ST_DIV1,
    ST_ANG, ST_BIAS, ST_P10, ST_P11, ST_P01, ST_P00, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_RB, OP_ANG_PRED, OP_DTP11, OP_MUL_INNER, OP_COV_PRED,
    OP_P11_PRED, OP_K0, OP_DIV1_GO, OP_K1, OP_ANG_UPD, OP_BIAS_UPD, OP_P10_UPD,
    OP_P11_UPD, OP_P01_UPD, OP_P00_UPD, OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    REG_ANGLE_NOISE = 2'd0,
    REG_BIAS_NOISE  = 2'd1,
    REG_MEAS_NOISE  = 2'd2,
    REG_START_ANGLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  localparam int DivSteps = 48;

  function automatic logic signed [71:0] sx32(input logic signed [31:0] a);
    sx32 = {{40{a[31]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sh0_0000_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -72'sh0_0000_0000_8000_0000) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

### rtl/kalman_angle_bias_filter.sv
// Top level of the two-state angle/bias Kalman filter.
//
// Input channel: in_valid/in_stall carry one item of measured angle, measured
// rate and time step. Result channel: out_valid/out_stall carry the filtered
// angle after the update. The configuration port writes the noise registers
// and the start angle with cfg_we, cfg_index and cfg_wdata; writing the start
// angle restarts the filter. Writes are to be made only while the block is
// idle; the block itself does not enforce this. One shared 36 x 33 multiplier
// runs the products one per cycle, and the two gain divisions each run on a
// bit-serial restoring divider. in_stall stays high from acceptance until the
// result has been moved to the output register, so one item is worked on
// at a time and no new item is taken before the last result has moved out.
// A result waits in the output register while out_stall is high; the next item
// is then accepted and computed, and its result is held back until the
// register is free. Synchronous reset loads the register defaults, the start
// angle of zero, zero bias and zero covariance, and empties the output.
`timescale 1ns / 1ps

module kalman_angle_bias_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [24:0] in_measured_angle,
  input  logic signed [27:0] in_measured_rate,
  input  logic [23:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_angle
);
  import kab_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kab_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_measured_angle  (in_measured_angle),
    .in_measured_rate   (in_measured_rate),
    .in_time_step       (in_time_step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_angle (out_filtered_angle),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

### rtl/kab_div.sv
// Serial restoring divider for the Kalman gains: (p * 65536) / s, saturated.
`timescale 1ns / 1ps

module kab_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  import kab_pkg::*;

  logic        running_r, running_nxt;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [47:0] n_r;
  logic [33:0] rem_r;
  logic [32:0] d_r;
  logic        neg_r;
  logic        zero_r;
  logic [31:0] mag;
  logic [33:0] rem_sh;
  logic signed [71:0] qx;

  assign mag    = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh = {rem_r[32:0], n_r[47]};

  always_comb begin
    running_nxt = running_r;
    if (start) begin
      running_nxt = 1'b1;
    end else if (running_r && cnt_r == 6'd0) begin
      running_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      done_r    <= running_r && cnt_r == 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= 6'(DivSteps - 1);
      n_r    <= {mag, 16'd0};
      rem_r  <= '0;
      d_r    <= den[32:0];
      neg_r  <= num[31];
      zero_r <= (den <= 34'sd0);
    end else if (running_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (rem_sh >= {1'b0, d_r}) begin
        rem_r <= rem_sh - {1'b0, d_r};
        n_r   <= {n_r[46:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        n_r   <= {n_r[46:0], 1'b0};
      end
    end
  end

  // The quotient magnitude may exceed 32 bits, so saturate after the sign.
  assign qx   = neg_r ? -$signed({24'd0, n_r}) : $signed({24'd0, n_r});
  assign quot = zero_r ? 32'sd0 : sat32(qx);
  assign done = done_r;

endmodule

### rtl/kab_ctrl.sv
// Sequencer of the predict and update steps of the Kalman filter.
`timescale 1ns / 1ps

module kab_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kab_pkg::sts_t sts,
  output kab_pkg::cmd_t cmd
);
  import kab_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MA;
      ST_MA:   state_nxt = ST_WA;
      ST_WA:   state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_MC;
      ST_MC:   state_nxt = ST_WC;
      ST_WC:   state_nxt = ST_WD;
      ST_WD:   state_nxt = ST_DIV0;
      ST_DIV0: if (sts.div_done) state_nxt = ST_D1GO;
      ST_D1GO: state_nxt = ST_DIV1;
      ST_DIV1: if (sts.div_done) state_nxt = ST_ANG;
      ST_ANG:  state_nxt = ST_BIAS;
      ST_BIAS: state_nxt = ST_P10;
      ST_P10:  state_nxt = ST_P11;
      ST_P11:  state_nxt = ST_P01;
      ST_P01:  state_nxt = ST_P00;
      ST_P00:  state_nxt = ST_DONE;
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_MA:   cmd.op = OP_MUL_RB;
      ST_WA:   cmd.op = OP_ANG_PRED;
      ST_WB:   cmd.op = OP_DTP11;
      ST_MC:   cmd.op = OP_MUL_INNER;
      ST_WC:   cmd.op = OP_COV_PRED;
      ST_WD:   cmd.op = OP_P11_PRED;
      ST_DIV0: if (sts.div_done) cmd.op = OP_K0;
      ST_D1GO: cmd.op = OP_DIV1_GO;
      ST_DIV1: if (sts.div_done) cmd.op = OP_K1;
      ST_ANG:  cmd.op = OP_ANG_UPD;
      ST_BIAS: cmd.op = OP_BIAS_UPD;
      ST_P10:  cmd.op = OP_P10_UPD;
      ST_P11:  cmd.op = OP_P11_UPD;
      ST_P01:  cmd.op = OP_P01_UPD;
      ST_P00:  cmd.op = OP_P00_UPD;
      ST_DONE: if (sts.out_free) cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/kab_dp.sv
// Datapath of the Kalman filter: state, registers, shared multiplier and divider.
`timescale 1ns / 1ps

module kab_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic signed [24:0] in_measured_angle,
  input  logic signed [27:0] in_measured_rate,
  input  logic [23:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_angle,
  input  kab_pkg::cmd_t      cmd,
  output kab_pkg::sts_t      sts
);
  import kab_pkg::*;

  logic [30:0]        apn_r, bpn_r, mn_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] k0_r, k1_r, y_r;
  logic signed [32:0] dtp11_r;
  logic signed [24:0] z_r;
  logic signed [27:0] rate_r;
  logic [23:0]        dt_r;
  logic signed [68:0] prod_r;
  logic               out_valid_r;
  logic signed [31:0] out_angle_r;

  logic signed [35:0] ma, inner;
  logic signed [32:0] mb;
  logic signed [71:0] prod_x, sh24, sh16;
  logic signed [33:0] s;
  logic signed [31:0] div_num, div_q;
  logic               div_go, div_done;

  assign prod_x = {{3{prod_r[68]}}, prod_r};
  assign sh24   = prod_x >>> 24;
  assign sh16   = prod_x >>> 16;
  assign inner  = {{3{dtp11_r[32]}}, dtp11_r} - {{4{p01_r[31]}}, p01_r}
                - {{4{p10_r[31]}}, p10_r} + {5'd0, apn_r};
  assign s      = {{2{p00_r[31]}}, p00_r} + {3'd0, mn_r};

  assign div_go  = (cmd.op == OP_P11_PRED) || (cmd.op == OP_DIV1_GO);
  assign div_num = (cmd.op == OP_DIV1_GO) ? p10_r : p00_r;

  kab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (s),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL_RB: begin
        ma = {{8{rate_r[27]}}, rate_r} - {{4{bias_r[31]}}, bias_r};
        mb = {9'd0, dt_r};
      end
      OP_ANG_PRED: begin
        ma = {{4{p11_r[31]}}, p11_r};
        mb = {9'd0, dt_r};
      end
      OP_MUL_INNER: begin
        ma = inner;
        mb = {9'd0, dt_r};
      end
      OP_COV_PRED: begin
        ma = {5'd0, bpn_r};
        mb = {9'd0, dt_r};
      end
      OP_K1: begin
        ma = {{4{k0_r[31]}}, k0_r};
        mb = {y_r[31], y_r};
      end
      OP_ANG_UPD: begin
        ma = {{4{k1_r[31]}}, k1_r};
        mb = {y_r[31], y_r};
      end
      OP_BIAS_UPD: begin
        ma = {{4{k1_r[31]}}, k1_r};
        mb = {p00_r[31], p00_r};
      end
      OP_P10_UPD: begin
        ma = {{4{k1_r[31]}}, k1_r};
        mb = {p01_r[31], p01_r};
      end
      OP_P11_UPD: begin
        ma = {{4{k0_r[31]}}, k0_r};
        mb = {p01_r[31], p01_r};
      end
      OP_P01_UPD: begin
        ma = {{4{k0_r[31]}}, k0_r};
        mb = {p00_r[31], p00_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apn_r  <= 31'd3277;
      bpn_r  <= 31'd590;
      mn_r   <= 31'd85197;
      ang_r  <= '0;
      bias_r <= '0;
      p00_r  <= '0;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ANGLE_NOISE: apn_r <= cfg_wdata;
        REG_BIAS_NOISE:  bpn_r <= cfg_wdata;
        REG_MEAS_NOISE:  mn_r  <= cfg_wdata;
        REG_START_ANGLE: begin
          // A new start angle restarts the filter.
          ang_r  <= {{7{cfg_wdata[24]}}, cfg_wdata[24:0]};
          bias_r <= '0;
          p00_r  <= '0;
          p01_r  <= '0;
          p10_r  <= '0;
          p11_r  <= '0;
        end
        default: apn_r <= apn_r;
      endcase
    end else begin
      unique case (cmd.op)
        OP_ANG_PRED: ang_r <= sat32(sx32(ang_r) + sh24);
        OP_COV_PRED: begin
          p00_r <= sat32(sx32(p00_r) + sh24);
          p01_r <= sat32(sx32(p01_r) - {{39{dtp11_r[32]}}, dtp11_r});
          p10_r <= sat32(sx32(p10_r) - {{39{dtp11_r[32]}}, dtp11_r});
        end
        OP_P11_PRED: p11_r  <= sat32(sx32(p11_r) + sh24);
        OP_ANG_UPD:  ang_r  <= sat32(sx32(ang_r) + sh16);
        OP_BIAS_UPD: bias_r <= sat32(sx32(bias_r) + sh16);
        OP_P10_UPD:  p10_r  <= sat32(sx32(p10_r) - sh16);
        OP_P11_UPD:  p11_r  <= sat32(sx32(p11_r) - sh16);
        OP_P01_UPD:  p01_r  <= sat32(sx32(p01_r) - sh16);
        OP_P00_UPD:  p00_r  <= sat32(sx32(p00_r) - sh16);
        default:     ang_r  <= ang_r;
      endcase
    end
  end

  // Item operands and intermediate values.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        z_r    <= in_measured_angle;
        rate_r <= in_measured_rate;
        dt_r   <= in_time_step;
      end
      OP_DTP11:    dtp11_r <= sh24[32:0];
      OP_P11_PRED: y_r <= sat32({{47{z_r[24]}}, z_r} - sx32(ang_r));
      OP_K0:       k0_r <= div_q;
      OP_K1:       k1_r <= div_q;
      default:     dtp11_r <= dtp11_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_angle_r <= ang_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign sts.div_done       = div_done;
  assign sts.out_free       = !out_valid_r || !out_stall;

endmodule
